// ----- rtl/spt_pkg.sv -----
// Shared constants for the sub-page protection tracker.
// Holds the opcode codes, the page geometry and the fixed field widths; no dependencies.
package spt_pkg;

    localparam int OP_W    = 3;
    localparam int ADDR_W  = 64;
    localparam int SPAN_W  = 24;
    localparam int PROT_W  = 3;
    localparam int FAULT_W = 32;

    // The slice count must be a power of two.
    localparam int SLICES_PER_PAGE  = 4;
    localparam int GUEST_PAGE_SHIFT = 12;

    localparam logic [OP_W-1:0] OP_SET_PROT    = 3'd0;
    localparam logic [OP_W-1:0] OP_GET_PROT    = 3'd1;
    localparam logic [OP_W-1:0] OP_IS_DIRTY    = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK_DIRTY  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR_DIRTY = 3'd4;
    localparam logic [OP_W-1:0] OP_VALIDATE    = 3'd5;

endpackage

// ----- rtl/spt_ram.sv -----
// Simple dual-port entry memory with a registered read port.
// Used by the tracker top level; no package dependencies.
module spt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 66,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sub_page_protection_tracker.sv -----
// Top level of the sub-page protection tracker.
// Depends on spt_pkg and spt_ram.
//
// One item is worked at a time. The host page and slice come straight from the address bits.
// Every lookup scans the entry memory one entry per cycle through its single read port, ending
// early on a hit, followed by an update step. Entries are allocated in order and never freed,
// so the entry count tells which entries are live. Range opcodes repeat the scan and update for
// each slice that they cover and then once more to form the result. A finished result waits in
// the output register while the next item is accepted; the block holds its last step only while
// that register is still occupied.
module sub_page_protection_tracker #(
    parameter int TABLE_ENTRIES    = 64,
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [spt_pkg::OP_W-1:0]    i_opcode,
    input  logic [spt_pkg::ADDR_W-1:0]  i_address,
    input  logic [spt_pkg::SPAN_W-1:0]  i_span_bytes,
    input  logic [spt_pkg::PROT_W-1:0]  i_new_prot,
    input  logic                        i_is_write,
    input  logic                        i_is_exec,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_ok,
    output logic [spt_pkg::PROT_W-1:0]  o_slice_prot_out,
    output logic                        o_dirty_out,
    output logic [spt_pkg::PROT_W-1:0]  o_host_prot_out,
    output logic                        o_table_full,
    output logic [CNT_W-1:0]            o_split_pages,
    output logic [CNT_W-1:0]            o_entries_used,
    output logic [spt_pkg::FAULT_W-1:0] o_fault_count
);
    import spt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SCN_W = $clog2(TABLE_ENTRIES + 1);
    localparam int G_W   = ADDR_W - GUEST_PAGE_SHIFT;
    localparam int SL_W  = $clog2(SLICES_PER_PAGE);
    localparam int ENT_W = G_W + (PROT_W + 1) * SLICES_PER_PAGE;
    localparam int RC_W  = SPAN_W + 2;

    localparam logic [SL_W:0]   SLICES   = (SL_W + 1)'(SLICES_PER_PAGE);
    localparam logic [SL_W-1:0] SL_LAST  = SL_W'(SLICES_PER_PAGE - 1);
    localparam logic [SCN_W-1:0] SCAN_END = SCN_W'(TABLE_ENTRIES);
    localparam logic [RC_W-1:0] GMASK    = RC_W'((1 << GUEST_PAGE_SHIFT) - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_EXEC = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    typedef logic [SLICES_PER_PAGE-1:0][PROT_W-1:0] t_prots;
    typedef logic [SLICES_PER_PAGE-1:0]             t_dirty;

    function automatic logic prots_differ(input t_prots p);
        logic s;
        s = 1'b0;
        for (int k = 1; k < SLICES_PER_PAGE; k++) begin
            if (p[k] != p[0]) s = 1'b1;
        end
        return s;
    endfunction

    function automatic logic [PROT_W-1:0] host_of(input t_prots p);
        logic [PROT_W-1:0] h;
        h = '0;
        for (int k = 0; k < SLICES_PER_PAGE; k++) begin
            if (p[k][0]) h[0] = 1'b1;
            if (p[k][1]) h[1:0] = 2'b11;
            if (p[k][2]) h[2] = 1'b1;
        end
        return h;
    endfunction

    logic [2:0]               r_state;
    logic [CNT_W-1:0]         r_used;
    logic [CNT_W-1:0]         r_split;
    logic [FAULT_W-1:0]       r_fault;
    logic                     r_full;

    logic [OP_W-1:0]   r_op;
    logic [PROT_W-1:0] r_new_prot;
    logic              r_wr;
    logic              r_ex;
    logic [G_W-1:0]    r_g;
    logic [G_W-1:0]    r_gp;
    logic [SL_W-1:0]   r_rem;
    logic [RC_W-1:0]   r_cnt;
    logic [G_W-1:0]    r_key;
    logic [G_W-1:0]    r_hpn0;
    logic              r_final;
    logic              r_range;

    logic [SCN_W-1:0]  r_idx;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_free_ok;
    logic [IDX_W-1:0]  r_free_idx;
    logic              r_hit;
    logic [IDX_W-1:0]  r_eidx;
    t_prots            r_ent_prot;
    t_dirty            r_ent_dirty;

    logic              r_res_ok;
    logic [PROT_W-1:0] r_res_sp;
    logic              r_res_dt;
    logic [PROT_W-1:0] r_res_hp;

    logic              r_o_valid;
    logic              r_o_ok;
    logic [PROT_W-1:0] r_o_sp;
    logic              r_o_dt;
    logic [PROT_W-1:0] r_o_hp;
    logic              r_o_full;
    logic [CNT_W-1:0]  r_o_split;
    logic [CNT_W-1:0]  r_o_used;
    logic [FAULT_W-1:0] r_o_fault;

    logic              accept;
    logic              rd_en;
    logic [ENT_W-1:0]  rdata;
    logic [G_W-1:0]    rd_tag;
    t_prots            rd_prot;
    t_dirty            rd_dirty;
    logic              rd_live;
    logic              rd_hit;
    logic              scan_end;
    logic [RC_W-1:0]   span_sum;
    logic [G_W-1:0]    acc_hpn;
    logic              acc_range;

    t_prots            cur_prot;
    t_dirty            cur_dirty;
    t_prots            n_prot;
    t_dirty            n_dirty;
    logic              can_alloc;
    logic              allow;
    logic              wr_ok;
    logic              we;
    logic [IDX_W-1:0]  widx;
    logic [PROT_W-1:0] slice_p;
    logic              split_old;
    logic              split_new;
    logic              walk_last;

    assign accept = i_valid && (r_state == ST_IDLE);
    assign o_stall = (r_state != ST_IDLE);

    assign rd_en    = (r_state == ST_SCAN) && (r_idx != SCAN_END);
    assign rd_tag   = rdata[ENT_W-1 -: G_W];
    assign rd_prot  = rdata[(PROT_W+1)*SLICES_PER_PAGE-1:SLICES_PER_PAGE];
    assign rd_dirty = rdata[SLICES_PER_PAGE-1:0];
    assign rd_live  = (CNT_W'(r_rd_idx) < r_used);
    assign rd_hit   = r_rd_vld && rd_live && (rd_tag == r_key);
    assign scan_end = rd_hit || (r_idx == SCAN_END);

    assign span_sum  = RC_W'(i_span_bytes) + (RC_W'(i_address) & GMASK) + GMASK;
    assign acc_hpn   = G_W'(i_address[ADDR_W-1:GUEST_PAGE_SHIFT+SL_W]);
    assign acc_range = (i_opcode == OP_SET_PROT) || (i_opcode == OP_CLEAR_DIRTY);

    assign walk_last = (r_cnt == RC_W'(1)) || (&r_gp);

    always_comb begin
        cur_prot  = r_hit ? r_ent_prot : '0;
        cur_dirty = r_hit ? r_ent_dirty : '0;
        n_prot    = cur_prot;
        n_dirty   = cur_dirty;
        can_alloc = !r_hit && r_free_ok;
        widx      = r_hit ? r_eidx : r_free_idx;
        slice_p   = cur_prot[r_rem];
        we        = 1'b0;
        allow     = r_hit && (slice_p != '0);
        wr_ok     = allow && r_wr && slice_p[1];
        if (allow && r_wr && !slice_p[1]) begin
            allow = 1'b0;
        end
        if (allow && r_ex && !slice_p[2]) begin
            allow = 1'b0;
        end
        unique case (r_op)
            OP_SET_PROT: begin
                if (r_hit || can_alloc) begin
                    n_prot[r_rem] = r_new_prot;
                    we = 1'b1;
                end
            end
            OP_CLEAR_DIRTY: begin
                n_dirty[r_rem] = 1'b0;
                we = r_hit;
            end
            OP_MARK_DIRTY: begin
                n_dirty[r_rem] = 1'b1;
                we = r_hit;
            end
            OP_VALIDATE: begin
                if (wr_ok) begin
                    n_dirty[r_rem] = 1'b1;
                end
                we = wr_ok;
            end
            default: begin
                we = 1'b0;
            end
        endcase
        we        = we && (r_state == ST_EXEC) && !r_final;
        split_old = r_hit && prots_differ(cur_prot);
        split_new = prots_differ(n_prot);
    end

    spt_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENT_W),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (widx),
        .i_wdata ({r_key, n_prot, n_dirty}),
        .i_re    (rd_en),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_used    <= '0;
            r_split   <= '0;
            r_fault   <= '0;
            r_full    <= 1'b0;
            r_o_valid <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rem     <= '0;
        end else begin
            if (r_o_valid && !i_stall && (r_state != ST_DONE)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_op       <= i_opcode;
                        r_new_prot <= i_new_prot;
                        r_wr       <= i_is_write;
                        r_ex       <= i_is_exec;
                        r_g        <= acc_hpn;
                        r_gp       <= i_address[ADDR_W-1:GUEST_PAGE_SHIFT];
                        r_rem      <= i_address[GUEST_PAGE_SHIFT+SL_W-1:GUEST_PAGE_SHIFT];
                        r_cnt      <= span_sum >> GUEST_PAGE_SHIFT;
                        r_range    <= acc_range;
                        r_key      <= acc_hpn;
                        r_hpn0     <= acc_hpn;
                        r_final    <= acc_range && (span_sum[RC_W-1:GUEST_PAGE_SHIFT] == '0);
                        r_idx      <= '0;
                        r_rd_vld   <= 1'b0;
                        r_free_ok  <= 1'b0;
                        r_full     <= 1'b0;
                        r_res_ok   <= 1'b0;
                        r_res_sp   <= '0;
                        r_res_dt   <= 1'b0;
                        r_res_hp   <= '0;
                        r_state    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_rd_vld <= rd_en;
                    r_rd_idx <= r_idx[IDX_W-1:0];
                    if (rd_en) begin
                        r_idx <= r_idx + SCN_W'(1);
                    end
                    if (r_rd_vld && !rd_live && !r_free_ok) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= r_rd_idx;
                    end
                    if (scan_end) begin
                        r_hit       <= rd_hit;
                        r_eidx      <= r_rd_idx;
                        r_ent_prot  <= rd_prot;
                        r_ent_dirty <= rd_dirty;
                        r_state     <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (r_final) begin
                        r_res_hp <= r_hit ? host_of(r_ent_prot) : '0;
                        r_res_ok <= (r_op == OP_SET_PROT) ? !r_full : 1'b1;
                        r_state  <= ST_DONE;
                    end else if (r_range) begin
                        if (r_op == OP_SET_PROT) begin
                            if (r_hit || can_alloc) begin
                                if (!r_hit) begin
                                    r_used <= r_used + CNT_W'(1);
                                end
                                if (split_new && !split_old) begin
                                    r_split <= r_split + CNT_W'(1);
                                end else if (split_old && !split_new) begin
                                    r_split <= r_split - CNT_W'(1);
                                end
                            end else begin
                                r_full <= 1'b1;
                            end
                        end
                        if (walk_last) begin
                            r_key   <= r_hpn0;
                            r_final <= 1'b1;
                        end else begin
                            r_gp  <= r_gp + G_W'(1);
                            r_cnt <= r_cnt - RC_W'(1);
                            if (r_rem == SL_LAST) begin
                                r_rem <= '0;
                                r_g   <= r_g + G_W'(1);
                                r_key <= r_g + G_W'(1);
                            end else begin
                                r_rem <= r_rem + SL_W'(1);
                            end
                        end
                        r_idx     <= '0;
                        r_rd_vld  <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_state   <= ST_SCAN;
                    end else begin
                        r_res_hp <= r_hit ? host_of(cur_prot) : '0;
                        case (r_op)
                            OP_GET_PROT: begin
                                r_res_ok <= 1'b1;
                                r_res_sp <= slice_p;
                            end
                            OP_IS_DIRTY: begin
                                r_res_ok <= 1'b1;
                                r_res_dt <= cur_dirty[r_rem];
                            end
                            OP_MARK_DIRTY: begin
                                r_res_ok <= 1'b1;
                            end
                            OP_VALIDATE: begin
                                r_res_ok <= allow;
                                if (!allow && !(&r_fault)) begin
                                    r_fault <= r_fault + FAULT_W'(1);
                                end
                            end
                            default: begin
                                r_res_ok <= 1'b0;
                            end
                        endcase
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        r_o_ok    <= r_res_ok;
                        r_o_sp    <= r_res_sp;
                        r_o_dt    <= r_res_dt;
                        r_o_hp    <= r_res_hp;
                        r_o_full  <= (r_op == OP_SET_PROT) && r_full;
                        r_o_split <= r_split;
                        r_o_used  <= r_used;
                        r_o_fault <= r_fault;
                        r_state   <= ST_IDLE;
                    end else begin
                        r_o_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_o_valid;
    assign o_ok             = r_o_ok;
    assign o_slice_prot_out = r_o_sp;
    assign o_dirty_out      = r_o_dt;
    assign o_host_prot_out  = r_o_hp;
    assign o_table_full     = r_o_full;
    assign o_split_pages    = r_o_split;
    assign o_entries_used   = r_o_used;
    assign o_fault_count    = r_o_fault;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count exceeds table size");

    a_split_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_split <= r_used)
        else $error("split count exceeds entry count");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SL_W + 1)'(r_rem) < SLICES)
        else $error("slice index out of range");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_full) |-> r_used == CNT_W'(TABLE_ENTRIES))
        else $error("table full flagged with free entries");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the sub-page protection tracker.
// Depends on spt_pkg and the sub_page_protection_tracker RTL; it predicts every result itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spt_pkg::*;

    localparam int ENTRIES = 64;
    localparam int SLICES = 4;
    localparam int CNT_W = 7;
    localparam int IDLE_LIMIT = 200000;
    localparam int LONG_HOLD = 300;
    localparam int POOL_SIZE = 24;
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic              ok;
        logic [PROT_W-1:0] slot_rights;
        logic              dirty;
        logic [PROT_W-1:0] page_rights;
        logic              full;
        logic [CNT_W-1:0]  split;
        logic [CNT_W-1:0]  used;
        logic [FAULT_W-1:0] faults;
    } tracker_result_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [OP_W-1:0]      i_opcode;
    logic [ADDR_W-1:0]    i_address;
    logic [SPAN_W-1:0]    i_span_bytes;
    logic [PROT_W-1:0]    i_new_prot;
    logic                 i_is_write;
    logic                 i_is_exec;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_ok;
    logic [PROT_W-1:0]    o_slice_prot_out;
    logic                 o_dirty_out;
    logic [PROT_W-1:0]    o_host_prot_out;
    logic                 o_table_full;
    logic [CNT_W-1:0]     o_split_pages;
    logic [CNT_W-1:0]     o_entries_used;
    logic [FAULT_W-1:0]   o_fault_count;

    sub_page_protection_tracker i_dut (.*);

    // Predicted table contents.
    logic              pg_valid [ENTRIES];
    logic [49:0]       pg_number [ENTRIES];
    logic [PROT_W-1:0] pg_prot [ENTRIES][SLICES];
    logic              pg_dirty [ENTRIES][SLICES];
    int unsigned       pg_used;
    int unsigned       pg_split;
    logic [FAULT_W-1:0] pg_faults;

    tracker_result_t expected_results[$];
    logic [49:0] page_pool[POOL_SIZE];
    int error_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int full_seen = 0;
    int idle_cycles = 0;
    bit quiet = 0;
    bit hold_request = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int lookup_page(logic [49:0] hpn);
        for (int i = 0; i < ENTRIES; i++)
            if (pg_valid[i] && pg_number[i] == hpn)
                return i;
        return -1;
    endfunction

    function automatic logic [PROT_W-1:0] rights_of_page(int e);
        logic [PROT_W-1:0] h;
        h = 0;
        for (int s = 0; s < SLICES; s++) begin
            if (pg_prot[e][s][0]) h |= 3'd1;
            if (pg_prot[e][s][1]) h |= 3'd3;
            if (pg_prot[e][s][2]) h |= 3'd4;
        end
        return h;
    endfunction

    function automatic tracker_result_t predict_access(logic [OP_W-1:0] op,
            logic [ADDR_W-1:0] addr, logic [SPAN_W-1:0] span,
            logic [PROT_W-1:0] prot, logic wr, logic ex);
        tracker_result_t r;
        logic [51:0] gp;
        logic [63:0] walk;
        int e;
        int x;
        int sl;
        logic allow;
        logic [PROT_W-1:0] p;
        r = '0;
        sl = addr[13:12];
        e = lookup_page(addr[63:14]);
        case (op)
            OP_SET_PROT, OP_CLEAR_DIRTY: begin
                walk = ({52'd0, addr[11:0]} + {40'd0, span} + 64'hFFF) >> 12;
                gp = addr[63:12];
                for (longint k = 0; k < walk; k++) begin
                    x = lookup_page(gp[51:2]);
                    if (op == OP_SET_PROT) begin
                        if (x < 0) begin
                            for (int i = 0; i < ENTRIES; i++) begin
                                if (!pg_valid[i]) begin
                                    pg_valid[i] = 1;
                                    pg_number[i] = gp[51:2];
                                    for (int s = 0; s < SLICES; s++) begin
                                        pg_prot[i][s] = 0;
                                        pg_dirty[i][s] = 0;
                                    end
                                    pg_used++;
                                    x = i;
                                    break;
                                end
                            end
                        end
                        if (x < 0) r.full = 1;
                        else pg_prot[x][gp[1:0]] = prot;
                    end else if (x >= 0) begin
                        pg_dirty[x][gp[1:0]] = 0;
                    end
                    if (gp == '1) break;
                    gp++;
                end
                if (op == OP_SET_PROT) begin
                    pg_split = 0;
                    for (int i = 0; i < ENTRIES; i++)
                        if (pg_valid[i])
                            for (int s = 1; s < SLICES; s++)
                                if (pg_prot[i][s] != pg_prot[i][0]) begin
                                    pg_split++;
                                    break;
                                end
                    r.ok = !r.full;
                end else begin
                    r.ok = 1;
                end
                e = lookup_page(addr[63:14]);
            end
            OP_GET_PROT: begin
                r.ok = 1;
                if (e >= 0) r.slot_rights = pg_prot[e][sl];
            end
            OP_IS_DIRTY: begin
                r.ok = 1;
                if (e >= 0) r.dirty = pg_dirty[e][sl];
            end
            OP_MARK_DIRTY: begin
                r.ok = 1;
                if (e >= 0) pg_dirty[e][sl] = 1;
            end
            OP_VALIDATE: begin
                allow = 0;
                if (e >= 0) begin
                    p = pg_prot[e][sl];
                    allow = p != 0;
                    if (allow && wr) begin
                        if (!p[1]) allow = 0;
                        else pg_dirty[e][sl] = 1;
                    end
                    if (allow && ex && !p[2]) allow = 0;
                end
                if (!allow && pg_faults != '1) pg_faults++;
                r.ok = allow;
            end
            default: ;
        endcase
        if (e >= 0) r.page_rights = rights_of_page(e);
        r.split = pg_split[CNT_W-1:0];
        r.used = pg_used[CNT_W-1:0];
        r.faults = pg_faults;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        error_count++;
        $display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, field, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            expected_results.push_back(predict_access(i_opcode, i_address, i_span_bytes,
                                                      i_new_prot, i_is_write, i_is_exec));
            items_sent++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no item outstanding", 1, 0);
            end else begin
                tracker_result_t w;
                w = expected_results.pop_front();
                if (o_ok !== w.ok) report_mismatch("ok", o_ok, w.ok);
                if (o_slice_prot_out !== w.slot_rights)
                    report_mismatch("slice protection", o_slice_prot_out, w.slot_rights);
                if (o_dirty_out !== w.dirty) report_mismatch("dirty", o_dirty_out, w.dirty);
                if (o_host_prot_out !== w.page_rights)
                    report_mismatch("host protection", o_host_prot_out, w.page_rights);
                if (o_table_full !== w.full) report_mismatch("table_full", o_table_full, w.full);
                if (o_split_pages !== w.split) report_mismatch("split", o_split_pages, w.split);
                if (o_entries_used !== w.used) report_mismatch("used", o_entries_used, w.used);
                if (o_fault_count !== w.faults)
                    report_mismatch("faults", o_fault_count, w.faults);
                if (w.full) full_seen++;
            end
            results_seen++;
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_stall = 1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_stall = 0;
                hold_request = 0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_stall = 1;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
                i_stall = 0;
            end
        end
    end

    // Called at a falling edge; returns at a falling edge after the item is taken.
    task automatic send_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
            logic [SPAN_W-1:0] span, logic [PROT_W-1:0] prot, logic wr, logic ex);
        i_opcode = op;
        i_address = addr;
        i_span_bytes = span;
        i_new_prot = prot;
        i_is_write = wr;
        i_is_exec = ex;
        i_valid = 1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid = 0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    task automatic test_untracked();
        logic [ADDR_W-1:0] a;
        a = {page_pool[0], 2'd2, 12'h123};
        send_item(OP_GET_PROT, a, 0, 0, 0, 0);
        send_item(OP_IS_DIRTY, a, 0, 0, 0, 0);
        send_item(OP_MARK_DIRTY, a, 0, 0, 0, 0);
        send_item(OP_CLEAR_DIRTY, a, 24'h4000, 0, 0, 0);
        send_item(OP_VALIDATE, a, 0, 0, 0, 0);
        send_item(OP_SPARE_A, a, 24'hFFFFFF, 3'd7, 1, 1);
        send_item(OP_SPARE_B, 64'd0, 0, 0, 0, 0);
    endtask

    task automatic test_protection();
        logic [ADDR_W-1:0] b;
        b = {page_pool[1], 14'd0};
        send_item(OP_SET_PROT, b, 0, 3'd7, 0, 0);
        send_item(OP_SET_PROT, b + 64'h10, 0, 3'd3, 0, 0);
        send_item(OP_SET_PROT, b + 64'h1000, 24'h2001, 3'd1, 0, 0);
        send_item(OP_SET_PROT, b + 64'h3FFF, 24'h2, 3'd7, 0, 0);
        for (int s = 0; s < SLICES; s++)
            send_item(OP_GET_PROT, b + 64'(s) * 64'h1000, 0, 0, 0, 0);
        send_item(OP_VALIDATE, b, 0, 0, 1, 1);
        send_item(OP_IS_DIRTY, b, 0, 0, 0, 0);
        send_item(OP_VALIDATE, b + 64'h1000, 0, 0, 1, 0);
        send_item(OP_VALIDATE, b + 64'h1000, 0, 0, 0, 1);
        send_item(OP_VALIDATE, b + 64'h4000, 0, 0, 0, 0);
        send_item(OP_SET_PROT, b + 64'h2000, 24'h1000, 3'd0, 0, 0);
        send_item(OP_VALIDATE, b + 64'h2000, 0, 0, 0, 0);
        send_item(OP_MARK_DIRTY, b + 64'h3000, 0, 0, 0, 0);
        send_item(OP_CLEAR_DIRTY, b + 64'h800, 24'h3000, 0, 0, 0);
        send_item(OP_IS_DIRTY, b + 64'h3000, 0, 0, 0, 0);
        send_item(OP_SET_PROT, 64'hFFFF_FFFF_FFFF_F800, 24'hFFFFFF, 3'd6, 0, 0);
        send_item(OP_VALIDATE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 1, 1);
        send_item(OP_CLEAR_DIRTY, 64'hFFFF_FFFF_FFFF_E000, 24'hFFFFFF, 0, 0, 0);
    endtask

    task automatic test_random(int count);
        logic [ADDR_W-1:0] a;
        logic [SPAN_W-1:0] span;
        logic [OP_W-1:0] op;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) op = OP_SET_PROT;
            else if (pick < 35) op = OP_GET_PROT;
            else if (pick < 45) op = OP_IS_DIRTY;
            else if (pick < 55) op = OP_MARK_DIRTY;
            else if (pick < 65) op = OP_CLEAR_DIRTY;
            else if (pick < 97) op = OP_VALIDATE;
            else op = pick[0] ? OP_SPARE_A : OP_SPARE_B;
            if ($urandom_range(0, 9) == 0) a = {$urandom, $urandom};
            else a = {page_pool[$urandom_range(0, POOL_SIZE - 1)], 14'($urandom)};
            if (a[63:16] == '1) span = 24'($urandom);
            else if ($urandom_range(0, 3) == 0) span = 24'($urandom_range(0, 16));
            else span = 24'($urandom_range(0, 16384));
            if ((op == OP_SET_PROT || op == OP_CLEAR_DIRTY) && a[63:16] != '1
                    && span > 24'h4000)
                span = 24'h4000;
            send_item(op, a, span, 3'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_backpressure();
        hold_request = 1;
        test_random(8);
    endtask

    task automatic test_table_full();
        logic [ADDR_W-1:0] b;
        b = {50'h1_2345_0000_0000, 14'd0};
        send_item(OP_SET_PROT, b, 24'd1146880, 3'd5, 0, 0);
        send_item(OP_SET_PROT, b + 64'h3000, 24'h1000, 3'd2, 0, 0);
        send_item(OP_VALIDATE, b + 64'd1146000, 0, 0, 0, 0);
        send_item(OP_SET_PROT, {$urandom, $urandom}, 24'h10, 3'd1, 0, 0);
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_opcode = OP_GET_PROT;
        i_address = 0;
        i_span_bytes = 0;
        i_new_prot = 0;
        i_is_write = 0;
        i_is_exec = 0;
        for (int i = 0; i < ENTRIES; i++) pg_valid[i] = 0;
        pg_used = 0;
        pg_split = 0;
        pg_faults = 0;
        for (int i = 0; i < POOL_SIZE - 1; i++) page_pool[i] = {$urandom, $urandom};
        page_pool[POOL_SIZE - 1] = '1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        test_untracked();
        test_protection();
        test_random(320);
        test_backpressure();
        test_random(250);
        test_table_full();
        quiet = 1;
        test_random(120);
        i_valid = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Ran %0d items and checked %0d results, %0d with a full table.",
                 items_sent, results_seen, full_seen);
        $display("Covered every opcode, range walks, the address-space top and back-pressure.");
        if (error_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/spt_pkg.sv
rtl/spt_ram.sv
rtl/sub_page_protection_tracker.sv
tb/sv/testbench.sv
